// ===== hdl/assert_macros.svh =====
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ===== hdl/mfds_pkg.sv =====
// types, constants and codes shared by the scheduler modules
`timescale 1ns / 1ps
`default_nettype none

package mfds_pkg;

	localparam int MAX_TASKS = 16;
	localparam int TIME_BITS = 16;

	// slot index width, task count width, time compare width
	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int N_W   = ($clog2(MAX_TASKS + 1) > 5) ? $clog2(MAX_TASKS + 1) : 5;
	localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

	// configuration register indexes
	localparam logic [1:0] REG_NUM_TASKS    = 2'd0;
	localparam logic [1:0] REG_HRT_MASK     = 2'd1;
	localparam logic [1:0] REG_FRAME_TICKS  = 2'd2;
	localparam logic [1:0] REG_CHECK_PERIOD = 2'd3;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_BEGIN = 3'd1,
		OP_START = 3'd2,
		OP_DONE  = 3'd3,
		OP_LOAD  = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		EV_ACK    = 3'd0,
		EV_MISS   = 3'd1,
		EV_FRESET = 3'd2,
		EV_SEL    = 3'd3,
		EV_NOSOFT = 3'd4,
		EV_REJECT = 3'd5
	} evkind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MISS,
		ST_SOFT_START,
		ST_SOFT_WALK
	} state_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [3:0]  task_index;
		logic [15:0] deadline_value;
	} mfds_in_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [3:0]  task_id;
		logic [15:0] frame_number;
		logic [15:0] frame_time;
		logic        last;
	} mfds_out_t;

	typedef struct packed {
		logic [N_W-1:0] n_eff;
		logic [15:0]    hrt_mask;
		logic [15:0]    frame_ticks;
		logic [15:0]    check_period;
	} cfg_t;

	// command broadcast to every cell
	typedef struct packed {
		logic                 clear;
		logic                 wr_en;
		opcode_t              wr_op;
		logic [IDX_W-1:0]     wr_slot;
		logic [TIME_BITS-1:0] wr_dl;
		logic                 tick_chk;
		logic [TIME_BITS-1:0] now;
		logic                 tok_load;
		logic [IDX_W-1:0]     tok_slot;
		logic                 tok_clear;
		logic                 tok_shift;
		logic                 pend_ack;
	} cell_ctl_t;

	// status of one cell
	typedef struct packed {
		logic kill;
		logic pend;
		logic tok;
		logic miss_hit;
		logic soft_hit;
		logic hard_run;
	} cell_st_t;

	// status gathered over the row of cells
	typedef struct packed {
		logic             any_kill;
		logic             any_pend;
		logic             pend_other;
		logic             miss_hit;
		logic [IDX_W-1:0] miss_id;
		logic             soft_hit;
		logic [IDX_W-1:0] soft_id;
		logic             hard_run;
	} row_st_t;

endpackage

`default_nettype wire

// ===== hdl/mfds_regs.sv =====
// configuration registers of the scheduler
`timescale 1ns / 1ps
`default_nettype none

module mfds_regs import mfds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	logic [4:0]  num_tasks_q;
	logic [15:0] hrt_mask_q;
	logic [15:0] frame_ticks_q;
	logic [15:0] check_period_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_tasks_q    <= 5'd16;
			hrt_mask_q     <= 16'd0;
			frame_ticks_q  <= 16'd1000;
			check_period_q <= 16'd10;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_NUM_TASKS:    num_tasks_q    <= cfg_data[4:0];
				REG_HRT_MASK:     hrt_mask_q     <= cfg_data;
				REG_FRAME_TICKS:  frame_ticks_q  <= cfg_data;
				REG_CHECK_PERIOD: check_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// task count clamped to the number of cells
	always_comb begin
		cfg.n_eff = (N_W'(num_tasks_q) > N_W'(MAX_TASKS)) ? N_W'(MAX_TASKS)
			: N_W'(num_tasks_q);
		cfg.hrt_mask     = hrt_mask_q;
		cfg.frame_ticks  = frame_ticks_q;
		cfg.check_period = check_period_q;
	end

endmodule

`default_nettype wire

// ===== hdl/mfds_cell.sv =====
// one task slot: flags, deadline and a stage of the scan token chain
`timescale 1ns / 1ps
`default_nettype none

module mfds_cell import mfds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [IDX_W-1:0] slot,
	input  logic             in_use,
	input  logic             hard,
	input  logic             tok_in,
	output cell_st_t         st
);

	logic                 run_q;
	logic                 done_q;
	logic                 pend_q;
	logic                 tok_q;
	logic [TIME_BITS-1:0] dl_q;
	logic                 kill;
	logic                 wr_sel;

	// deadline check of a running hard task
	assign kill   = ctl.tick_chk & hard & in_use & run_q & (ctl.now >= dl_q);
	assign wr_sel = ctl.wr_en & (ctl.wr_slot == slot);

	// task flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (ctl.clear) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (kill) begin
				run_q  <= 1'b0;
				pend_q <= 1'b1;
			end else if (wr_sel) begin
				case (ctl.wr_op)
					OP_START: run_q <= 1'b1;
					OP_DONE: begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (ctl.pend_ack && tok_q && pend_q)
				pend_q <= 1'b0;
		end
	end

	// deadline store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dl_q <= '0;
		else if (wr_sel && ctl.wr_op == OP_LOAD)
			dl_q <= ctl.wr_dl;
	end

	// scan token, handed on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tok_q <= 1'b0;
		else if (ctl.tok_load)
			tok_q <= (ctl.tok_slot == slot);
		else if (ctl.tok_clear)
			tok_q <= 1'b0;
		else if (ctl.tok_shift)
			tok_q <= tok_in;
	end

	always_comb begin
		st.kill     = kill;
		st.pend     = pend_q;
		st.tok      = tok_q;
		st.miss_hit = tok_q & pend_q;
		st.soft_hit = tok_q & in_use & ~hard & ~done_q;
		st.hard_run = hard & in_use & run_q;
	end

endmodule

`default_nettype wire

// ===== hdl/mfds_seq.sv =====
// sequencer: frame timing, soft pointer, result register and cell commands
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mfds_seq import mfds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  mfds_in_t  cmd,
	output logic      evt_valid,
	input  logic      evt_ready,
	output mfds_out_t evt,
	input  cfg_t      cfg,
	input  row_st_t   row,
	output cell_ctl_t ctl
);

	state_t               state_q, state_d;
	logic                 active_q, active_d;
	logic [TIME_BITS-1:0] el_q, el_d;
	logic [15:0]          fc_q, fc_d;
	logic [15:0]          cc_q, cc_d;
	logic [IDX_W-1:0]     ptr_q, ptr_d;
	logic                 due_q, due_d;
	logic [N_W-1:0]       step_q, step_d;
	logic                 evt_valid_q;
	mfds_out_t            evt_q;

	logic                 can_load;
	logic                 accept;
	logic                 emit;
	mfds_out_t            ev;
	logic [TIME_BITS-1:0] e1;
	logic [15:0]          cc1;
	logic                 due;
	logic                 tick_reset;
	logic                 n_zero;
	logic                 walk_end;
	logic                 pend_left;
	logic                 idx_bad;
	logic [IDX_W-1:0]     p_norm;
	logic [N_W-1:0]       sel_nx;

	// shared conditions
	assign can_load   = ~evt_valid_q | evt_ready;
	assign cmd_ready  = (state_q == ST_IDLE) & can_load;
	assign accept     = cmd_valid & cmd_ready;
	assign e1         = el_q + TIME_BITS'(1);
	assign cc1        = cc_q + 16'd1;
	assign due        = cc1 >= cfg.check_period;
	assign tick_reset = CMP_W'(e1) >= CMP_W'(cfg.frame_ticks);
	assign n_zero     = cfg.n_eff == '0;
	assign walk_end   = step_q == (cfg.n_eff - N_W'(1));
	assign pend_left  = row.miss_hit ? row.pend_other : row.any_pend;
	assign idx_bad    = N_W'(cmd.task_index) >= cfg.n_eff;
	assign p_norm     = (N_W'(ptr_q) >= cfg.n_eff) ? '0 : ptr_q;
	assign sel_nx     = N_W'(row.soft_id) + N_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.opcode == OP_TICK && active_q && !tick_reset) begin
					if (row.any_kill)
						state_d = ST_MISS;
					else if (due)
						state_d = ST_SOFT_START;
				end
			end
			ST_MISS: begin
				if (can_load && !pend_left)
					state_d = due_q ? ST_SOFT_START : ST_IDLE;
			end
			ST_SOFT_START: begin
				if (can_load)
					state_d = (row.hard_run || n_zero) ? ST_IDLE : ST_SOFT_WALK;
			end
			ST_SOFT_WALK: begin
				if (can_load && (row.soft_hit || walk_end))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// results, cell commands and register updates
	always_comb begin
		active_d = active_q;
		el_d     = el_q;
		fc_d     = fc_q;
		cc_d     = cc_q;
		ptr_d    = ptr_q;
		due_d    = due_q;
		step_d   = step_q;
		emit     = 1'b0;
		ev.event_kind   = EV_ACK;
		ev.task_id      = 4'd0;
		ev.frame_number = fc_q;
		ev.frame_time   = 16'(el_q);
		ev.last         = 1'b1;
		ctl = '0;
		ctl.wr_op    = OP_TICK;
		ctl.wr_slot  = IDX_W'(cmd.task_index);
		ctl.wr_dl    = TIME_BITS'(cmd.deadline_value);
		ctl.now      = e1;
		ctl.tok_slot = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					emit = 1'b1;
					case (cmd.opcode)
						OP_TICK: begin
							if (!active_q) begin
								ev.event_kind = EV_REJECT;
							end else if (tick_reset) begin
								// end of major frame
								ctl.clear       = 1'b1;
								ptr_d           = '0;
								fc_d            = fc_q + 16'd1;
								el_d            = '0;
								cc_d            = 16'd0;
								ev.event_kind   = EV_FRESET;
								ev.frame_number = fc_q + 16'd1;
								ev.frame_time   = 16'd0;
							end else begin
								ctl.tick_chk  = 1'b1;
								el_d          = e1;
								cc_d          = due ? 16'd0 : cc1;
								due_d         = due;
								ev.frame_time = 16'(e1);
								if (row.any_kill) begin
									emit         = 1'b0;
									ctl.tok_load = 1'b1;
								end else if (due) begin
									emit = 1'b0;
								end
							end
						end
						OP_BEGIN: begin
							ctl.clear       = 1'b1;
							active_d        = 1'b1;
							fc_d            = 16'd1;
							el_d            = '0;
							cc_d            = 16'd0;
							ptr_d           = '0;
							ev.frame_number = 16'd1;
							ev.frame_time   = 16'd0;
						end
						OP_START, OP_DONE, OP_LOAD: begin
							ev.task_id = cmd.task_index;
							if (idx_bad) begin
								ev.event_kind = EV_REJECT;
							end else begin
								ctl.wr_en = 1'b1;
								ctl.wr_op = opcode_t'(cmd.opcode);
							end
						end
						default: ev.event_kind = EV_REJECT;
					endcase
				end
			end
			ST_MISS: begin
				// token walks the row, one miss beat per killed task
				if (can_load) begin
					ctl.tok_shift = 1'b1;
					if (row.miss_hit) begin
						emit          = 1'b1;
						ctl.pend_ack  = 1'b1;
						ev.event_kind = EV_MISS;
						ev.task_id    = 4'(row.miss_id);
						ev.last       = ~due_q & ~row.pend_other;
					end
					if (!pend_left)
						ctl.tok_clear = 1'b1;
				end
			end
			ST_SOFT_START: begin
				if (can_load) begin
					if (row.hard_run || n_zero) begin
						emit          = 1'b1;
						ev.event_kind = EV_NOSOFT;
						if (n_zero)
							ptr_d = '0;
					end else begin
						ctl.tok_load = 1'b1;
						ctl.tok_slot = p_norm;
						ptr_d        = p_norm;
						step_d       = '0;
					end
				end
			end
			ST_SOFT_WALK: begin
				// round robin search along the ring of slots in use
				if (can_load) begin
					if (row.soft_hit) begin
						emit          = 1'b1;
						ev.event_kind = EV_SEL;
						ev.task_id    = 4'(row.soft_id);
						ptr_d         = (sel_nx >= cfg.n_eff) ? '0 : IDX_W'(sel_nx);
						ctl.tok_clear = 1'b1;
					end else if (walk_end) begin
						emit          = 1'b1;
						ev.event_kind = EV_NOSOFT;
						ctl.tok_clear = 1'b1;
					end else begin
						step_d        = step_q + N_W'(1);
						ctl.tok_shift = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// control and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= 1'b0;
			el_q     <= '0;
			fc_q     <= 16'd0;
			cc_q     <= 16'd0;
			ptr_q    <= '0;
			due_q    <= 1'b0;
			step_q   <= '0;
		end else begin
			state_q  <= state_d;
			active_q <= active_d;
			el_q     <= el_d;
			fc_q     <= fc_d;
			cc_q     <= cc_d;
			ptr_q    <= ptr_d;
			due_q    <= due_d;
			step_q   <= step_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			evt_valid_q <= 1'b0;
		else if (emit)
			evt_valid_q <= 1'b1;
		else if (evt_ready)
			evt_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit)
			evt_q <= ev;
	end

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

	`ASSERT_AT(a_miss_has_pend, clk, arst_n, (state_q == ST_MISS) |-> row.any_pend, "miss walk without pending miss")
	`ASSERT_AT(a_walk_bound, clk, arst_n, (state_q == ST_SOFT_WALK) |-> (step_q < cfg.n_eff), "soft walk past slot count")
	`ASSERT_NEVER(a_emit_full, clk, arst_n, emit && evt_valid_q && !evt_ready, "result beat overwrites pending beat")

endmodule

`default_nettype wire

// ===== hdl/major_frame_deadline_scheduler.sv =====
// Major frame deadline scheduler: row of task cells under a sequencer.
// Begin frame, task ops, rejects, plain ticks and frame reset give one beat, registered in the cycle after accept.
// Tick with misses: the token walks from slot 0 up to the highest missed slot, one beat per miss.
// Soft check: a hard check in ST_SOFT_START, then a token walk over the slots in use (up to n).
// Next command accepted once the sequencer is idle and the result register is free.
// Reset (arst_n low, asynchronous): frame inactive, all flags, deadlines and counters zero.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module major_frame_deadline_scheduler import mfds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  mfds_in_t  cmd,
	output logic      evt_valid,
	input  logic      evt_ready,
	output mfds_out_t evt,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data
);

	cfg_t                 cfg;
	cell_ctl_t            ctl;
	row_st_t              row;
	cell_st_t             st [MAX_TASKS];
	logic [MAX_TASKS-1:0] in_use;
	logic [MAX_TASKS-1:0] hard;
	logic [MAX_TASKS-1:0] is_last;
	logic [MAX_TASKS-1:0] tok_vec;
	logic [MAX_TASKS-1:0] tok_in;

	mfds_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	mfds_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.cfg       (cfg),
		.row       (row),
		.ctl       (ctl)
	);

	// per slot attributes and the token ring closed at the last slot in use
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		assign in_use[i] = N_W'(i) < cfg.n_eff;
		if (i < 16) begin : g_hard
			assign hard[i] = cfg.hrt_mask[i];
		end else begin : g_soft
			assign hard[i] = 1'b0;
		end
		if (i + 1 < MAX_TASKS) begin : g_mid
			assign is_last[i] = in_use[i] & ~in_use[i+1];
		end else begin : g_end
			assign is_last[i] = in_use[i];
		end
		if (i == 0) begin : g_head
			assign tok_in[i] = |(tok_vec & is_last);
		end else begin : g_link
			assign tok_in[i] = tok_vec[i-1] & ~is_last[i-1];
		end
		assign tok_vec[i] = st[i].tok;

		mfds_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.slot   (IDX_W'(i)),
			.in_use (in_use[i]),
			.hard   (hard[i]),
			.tok_in (tok_in[i]),
			.st     (st[i])
		);
	end

	// row status reductions
	always_comb begin
		row = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			row.any_kill   = row.any_kill | st[i].kill;
			row.any_pend   = row.any_pend | st[i].pend;
			row.pend_other = row.pend_other | (st[i].pend & ~st[i].tok);
			row.miss_hit   = row.miss_hit | st[i].miss_hit;
			row.soft_hit   = row.soft_hit | st[i].soft_hit;
			row.hard_run   = row.hard_run | st[i].hard_run;
			if (st[i].miss_hit)
				row.miss_id = row.miss_id | IDX_W'(i);
			if (st[i].soft_hit)
				row.soft_id = row.soft_id | IDX_W'(i);
		end
	end

	`ASSERT_AT(a_tok_onehot, clk, arst_n, $onehot0(tok_vec), "more than one scan token")
	`ASSERT_NEVER(a_tok_in_use, clk, arst_n, |(tok_vec & ~in_use), "scan token in unused slot")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench for the major frame deadline scheduler: directed and random commands
`timescale 1ns / 1ps

module testbench;
	import mfds_pkg::*;

	// opcodes the block must reject
	localparam logic [2:0] OP_BAD_FIRST = 3'd5;
	localparam logic [2:0] OP_BAD_LAST  = 3'd7;
	localparam int MAX_GAP = 18;
	localparam int SETTLE  = 40;

	// expected event stream plus a copy of the scheduler state
	class sched_scoreboard;
		bit [4:0]  num_tasks;
		bit [15:0] hrt_mask;
		bit [15:0] frame_ticks;
		bit [15:0] check_period;
		bit [15:0] running;
		bit [15:0] completed;
		bit [15:0] missed;
		bit [15:0] deadlines [16];
		bit        active;
		bit [15:0] elapsed;
		bit [15:0] frame_cnt;
		bit [15:0] check_cnt;
		int        soft_ptr;
		mfds_out_t pending_events [$];
		int        mismatches;

		function new();
			num_tasks = 5'd16;
			hrt_mask = '0;
			frame_ticks = 16'd1000;
			check_period = 16'd10;
			running = '0;
			completed = '0;
			missed = '0;
			foreach (deadlines[i]) deadlines[i] = '0;
			active = 1'b0;
			elapsed = '0;
			frame_cnt = '0;
			check_cnt = '0;
			soft_ptr = 0;
			mismatches = 0;
		endfunction

		function int slots();
			return (num_tasks > 5'd16) ? 16 : int'(num_tasks);
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				REG_NUM_TASKS:    num_tasks = data[4:0];
				REG_HRT_MASK:     hrt_mask = data;
				REG_FRAME_TICKS:  frame_ticks = data;
				REG_CHECK_PERIOD: check_period = data;
				default: ;
			endcase
		endfunction

		function void push_event(evkind_t kind, logic [3:0] id);
			mfds_out_t r;
			r.event_kind = kind;
			r.task_id = id;
			r.frame_number = frame_cnt;
			r.frame_time = elapsed;
			r.last = 1'b0;
			pending_events.push_back(r);
		endfunction

		function void clear_flags();
			running = '0;
			completed = '0;
			missed = '0;
			soft_ptr = 0;
		endfunction

		// round robin pick of the next uncompleted soft task, none while a hard task runs
		function void pick_soft();
			int n;
			int idx;
			n = slots();
			for (int i = 0; i < n; i++) begin
				if (hrt_mask[i] && running[i]) begin
					push_event(EV_NOSOFT, '0);
					return;
				end
			end
			if (soft_ptr >= n) soft_ptr = 0;
			for (int a = 0; a < n; a++) begin
				idx = soft_ptr;
				soft_ptr = (idx + 1 >= n) ? 0 : idx + 1;
				if (!hrt_mask[idx] && !completed[idx]) begin
					push_event(EV_SEL, idx[3:0]);
					return;
				end
			end
			push_event(EV_NOSOFT, '0);
		endfunction

		// advance frame time, then frame reset or deadline kills and soft check
		function void tick();
			int n;
			int before_cnt;
			n = slots();
			before_cnt = pending_events.size();
			elapsed = elapsed + 16'd1;
			if (elapsed >= frame_ticks) begin
				clear_flags();
				frame_cnt = frame_cnt + 16'd1;
				elapsed = '0;
				check_cnt = '0;
				push_event(EV_FRESET, '0);
				return;
			end
			for (int i = 0; i < n; i++) begin
				if (hrt_mask[i] && running[i] && elapsed >= deadlines[i]) begin
					running[i] = 1'b0;
					missed[i] = 1'b1;
					push_event(EV_MISS, i[3:0]);
				end
			end
			check_cnt = check_cnt + 16'd1;
			if (check_cnt >= check_period) begin
				check_cnt = '0;
				pick_soft();
			end
			if (pending_events.size() == before_cnt) push_event(EV_ACK, '0);
		endfunction

		function void note_command(mfds_in_t c);
			case (c.opcode)
				OP_TICK: begin
					if (!active) push_event(EV_REJECT, '0);
					else tick();
				end
				OP_BEGIN: begin
					active = 1'b1;
					clear_flags();
					frame_cnt = 16'd1;
					elapsed = '0;
					check_cnt = '0;
					push_event(EV_ACK, '0);
				end
				OP_START, OP_DONE, OP_LOAD: begin
					if (int'(c.task_index) >= slots()) begin
						push_event(EV_REJECT, c.task_index);
					end else begin
						if (c.opcode == OP_START) begin
							running[c.task_index] = 1'b1;
						end else if (c.opcode == OP_DONE) begin
							running[c.task_index] = 1'b0;
							completed[c.task_index] = 1'b1;
						end else begin
							deadlines[c.task_index] = c.deadline_value;
						end
						push_event(EV_ACK, c.task_index);
					end
				end
				default: push_event(EV_REJECT, '0);
			endcase
			pending_events[$].last = 1'b1;
		endfunction

		function void check_event(mfds_out_t got);
			mfds_out_t want;
			if (pending_events.size() == 0) begin
				$error("event with none expected: kind %0d task %0d", got.event_kind, got.task_id);
				mismatches++;
				return;
			end
			want = pending_events.pop_front();
			if (got.event_kind !== want.event_kind) begin
				$error("event_kind expected %0d got %0d", want.event_kind, got.event_kind);
				mismatches++;
			end
			if (got.task_id !== want.task_id) begin
				$error("task_id expected %0d got %0d", want.task_id, got.task_id);
				mismatches++;
			end
			if (got.frame_number !== want.frame_number) begin
				$error("frame_number expected %0d got %0d", want.frame_number, got.frame_number);
				mismatches++;
			end
			if (got.frame_time !== want.frame_time) begin
				$error("frame_time expected %0d got %0d", want.frame_time, got.frame_time);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last expected %0d got %0d", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	mfds_in_t    cmd = '0;
	logic        evt_valid;
	logic        evt_ready = 1'b0;
	mfds_out_t   evt;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = REG_NUM_TASKS;
	logic [15:0] cfg_data = '0;

	sched_scoreboard sb;
	bit quiet = 1'b0;

	major_frame_deadline_scheduler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#(50_000_000);
		$display("FAILURE");
		$finish;
	end

	function automatic mfds_in_t make_cmd(logic [2:0] op, logic [3:0] idx, logic [15:0] dl);
		mfds_in_t c;
		c.opcode = op;
		c.task_index = idx;
		c.deadline_value = dl;
		return c;
	endfunction

	// one command beat, called and returning at a falling edge
	task automatic send_cmd(mfds_in_t c);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		sb.note_command(c);
		@(negedge clk);
	endtask

	// hold off until every expected event is out and the block has settled
	task automatic drain();
		cmd_valid <= 1'b0;
		while (sb.pending_events.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_config(logic [4:0] n, logic [15:0] hrt, logic [15:0] ft, logic [15:0] cp);
		cfg_we <= 1'b1;
		cfg_idx <= REG_NUM_TASKS;
		cfg_data <= {11'd0, n};
		sb.write_reg(REG_NUM_TASKS, {11'd0, n});
		@(negedge clk);
		cfg_idx <= REG_HRT_MASK;
		cfg_data <= hrt;
		sb.write_reg(REG_HRT_MASK, hrt);
		@(negedge clk);
		cfg_idx <= REG_FRAME_TICKS;
		cfg_data <= ft;
		sb.write_reg(REG_FRAME_TICKS, ft);
		@(negedge clk);
		cfg_idx <= REG_CHECK_PERIOD;
		cfg_data <= cp;
		sb.write_reg(REG_CHECK_PERIOD, cp);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// event side: random stalls, check every beat
	initial begin : event_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				evt_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			evt_ready <= 1'b1;
			do @(posedge clk); while (!evt_valid);
			sb.check_event(evt);
		end
	end

	initial begin : stimulus
		int unsigned r;
		int n_eff;
		logic [2:0]  op;
		logic [3:0]  idx;
		logic [15:0] dl;
		logic [4:0]  n_cfg;
		logic [15:0] hrt_cfg;
		logic [15:0] ft_cfg;
		logic [15:0] cp_cfg;

		sb = new();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: inactive tick, unknown opcode, basic task ops
		send_cmd(make_cmd(OP_TICK, 4'd0, 16'd0));
		send_cmd(make_cmd(OP_BAD_LAST, 4'd15, 16'hFFFF));
		send_cmd(make_cmd(OP_BEGIN, 4'd0, 16'd0));
		send_cmd(make_cmd(OP_LOAD, 4'd15, 16'hFFFF));
		send_cmd(make_cmd(OP_START, 4'd15, 16'd0));
		send_cmd(make_cmd(OP_DONE, 4'd15, 16'd0));
		send_cmd(make_cmd(OP_TICK, 4'd0, 16'd0));
		drain();

		// short frame with hard tasks: misses, no-soft, selection, out of range slots
		set_config(5'd4, 16'h0005, 16'd6, 16'd2);
		send_cmd(make_cmd(OP_BEGIN, 4'd0, 16'd0));
		send_cmd(make_cmd(OP_LOAD, 4'd0, 16'd2));
		send_cmd(make_cmd(OP_LOAD, 4'd2, 16'd3));
		send_cmd(make_cmd(OP_START, 4'd0, 16'd0));
		send_cmd(make_cmd(OP_START, 4'd1, 16'd0));
		send_cmd(make_cmd(OP_START, 4'd2, 16'd0));
		send_cmd(make_cmd(OP_START, 4'd4, 16'd0));
		send_cmd(make_cmd(OP_DONE, 4'd9, 16'd0));
		send_cmd(make_cmd(OP_LOAD, 4'd12, 16'h8000));
		repeat (4) send_cmd(make_cmd(OP_TICK, 4'd0, 16'd0));
		send_cmd(make_cmd(OP_DONE, 4'd1, 16'd0));
		repeat (2) send_cmd(make_cmd(OP_TICK, 4'd0, 16'd0));
		drain();

		// zero task count, zero frame length, zero check period
		set_config(5'd0, 16'hFFFF, 16'd0, 16'd0);
		send_cmd(make_cmd(OP_TICK, 4'd0, 16'd0));
		send_cmd(make_cmd(OP_START, 4'd0, 16'd0));
		drain();
		set_config(5'd31, 16'h0000, 16'd3, 16'd0);
		send_cmd(make_cmd(OP_BEGIN, 4'd0, 16'd0));
		repeat (3) send_cmd(make_cmd(OP_TICK, 4'd0, 16'd0));
		drain();

		// random phases, each with its own settings
		for (int p = 0; p < 12; p++) begin
			case ($urandom_range(0, 5))
				0: n_cfg = 5'd0;
				1: n_cfg = 5'd1;
				2: n_cfg = 5'd16;
				3: n_cfg = 5'($urandom_range(17, 31));
				default: n_cfg = 5'($urandom_range(2, 15));
			endcase
			case ($urandom_range(0, 3))
				0: hrt_cfg = 16'h0000;
				1: hrt_cfg = 16'hFFFF;
				default: hrt_cfg = 16'($urandom);
			endcase
			case ($urandom_range(0, 7))
				0: ft_cfg = 16'd0;
				1: ft_cfg = 16'hFFFF;
				2: ft_cfg = 16'd1;
				default: ft_cfg = 16'($urandom_range(4, 40));
			endcase
			case ($urandom_range(0, 5))
				0: cp_cfg = 16'd0;
				1: cp_cfg = 16'hFFFF;
				2: cp_cfg = 16'd1;
				default: cp_cfg = 16'($urandom_range(2, 6));
			endcase
			set_config(n_cfg, hrt_cfg, ft_cfg, cp_cfg);
			quiet = (p % 4 == 3);
			if ($urandom_range(0, 9) < 7) send_cmd(make_cmd(OP_BEGIN, 4'd0, 16'd0));

			for (int k = 0; k < 36; k++) begin
				r = $urandom_range(0, 99);
				n_eff = sb.slots();
				if (n_eff == 0 || $urandom_range(0, 4) == 0) idx = 4'($urandom_range(0, 15));
				else idx = 4'($urandom_range(0, n_eff - 1));
				if ($urandom_range(0, 2) == 0) dl = 16'($urandom);
				else dl = 16'($urandom_range(0, int'(sb.frame_ticks) + 2));
				if (r < 45) op = OP_TICK;
				else if (r < 48) op = OP_BEGIN;
				else if (r < 63) op = OP_START;
				else if (r < 75) op = OP_DONE;
				else if (r < 92) op = OP_LOAD;
				else if (r < 95) op = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
				else op = OP_TICK;
				send_cmd(make_cmd(op, idx, dl));
				if ($urandom_range(0, 40) == 0) drain();
			end
			drain();
		end

		quiet = 1'b0;
		drain();
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== major_frame_deadline_scheduler.f =====
+incdir+hdl
hdl/mfds_pkg.sv
hdl/mfds_regs.sv
hdl/mfds_cell.sv
hdl/mfds_seq.sv
hdl/major_frame_deadline_scheduler.sv
test/testbench.sv
